// ----- hdl/dalwb_pkg.sv -----
package dalwb_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = IDX_W + 1;
	localparam int VAL_W  = 32;
	localparam int SEQ_W  = 31;
	localparam int TIME_W = 31;

	localparam logic [1:0] ST_ADD_OK   = 2'd0;
	localparam logic [1:0] ST_ADD_DROP = 2'd1;
	localparam logic [1:0] ST_RD_FRESH = 2'd2;
	localparam logic [1:0] ST_RD_HELD  = 2'd3;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic [VAL_W-1:0]  value;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] arr_time;
	} entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [CNT_W-1:0] rd_idx;
		logic             wr_en;
		logic [CNT_W-1:0] wr_idx;
		logic             adv_en;
		logic [CNT_W-1:0] adv_cnt;
	} ring_cmd_t;

endpackage

// ----- hdl/dalwb_ring.sv -----
module dalwb_ring (
	input  logic                clk,
	input  logic                arst_n,
	input  dalwb_pkg::ring_cmd_t cmd,
	input  dalwb_pkg::entry_t   wr_data,
	output dalwb_pkg::entry_t   rd_data
);
	import dalwb_pkg::*;

	entry_t           mem [DEPTH];
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] rd_phys;
	logic [IDX_W-1:0] wr_phys;
	logic [IDX_W-1:0] adv_phys;

	function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] ofs);
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] red;
		sum = {1'b0, base} + SUM_W'(ofs);
		red = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
		return red[IDX_W-1:0];
	endfunction

	assign rd_phys  = wrap(head_q, cmd.rd_idx);
	assign wr_phys  = wrap(head_q, cmd.wr_idx);
	assign adv_phys = wrap(head_q, cmd.adv_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (cmd.adv_en) begin
			head_q <= adv_phys;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_phys] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data <= mem[rd_phys];
		end
	end

endmodule

// ----- hdl/delayed_arrival_latest_wins_buffer.sv -----
// channel   | handshake         | fields
// ----------+-------------------+--------------------------------------------------
// request   | start / busy      | req_type, sample_value, sample_seq, arrival_time,
//           |                   | now_time
// result    | done (one cycle)  | out_value, status
//
// A request is taken when start is high and busy is low; done follows the last busy cycle.
// An add to a full buffer is dropped and answered with done without busy going high.
// Any other add moves each of the m entries with a later arrival time one slot through the
// entry ring; a read scans the d due entries, one per ring read.
// Reset empties the buffer and clears the held value and sequence at once.
// done is high for exactly one cycle per request; the receiver cannot stall.
module delayed_arrival_latest_wins_buffer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                req_type,
	input  logic signed [31:0]  sample_value,
	input  logic [30:0]         sample_seq,
	input  logic [30:0]         arrival_time,
	input  logic [30:0]         now_time,
	output logic                done,
	output logic signed [31:0]  out_value,
	output logic [1:0]          status
);
	import dalwb_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_ADD_RD  = 3'd1;
	localparam logic [2:0] S_ADD_CMP = 3'd2;
	localparam logic [2:0] S_INS     = 3'd3;
	localparam logic [2:0] S_RD_RD   = 3'd4;
	localparam logic [2:0] S_RD_CMP  = 3'd5;
	localparam logic [2:0] S_RD_FIN  = 3'd6;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  k_q;
	logic [VAL_W-1:0]  val_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [TIME_W-1:0] time_q;
	logic [SEQ_W-1:0]  best_seq_q;
	logic [VAL_W-1:0]  best_val_q;
	logic              fresh_q;
	logic [VAL_W-1:0]  held_value_q;
	logic [SEQ_W-1:0]  held_seq_q;
	logic              done_q;
	logic [VAL_W-1:0]  out_value_q;
	logic [1:0]        status_q;

	ring_cmd_t cmd;
	entry_t    wr_data;
	entry_t    rd_data;
	logic      accept;

	dalwb_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign out_value = $signed(out_value_q);
	assign status    = status_q;

	always_comb begin
		cmd     = '0;
		wr_data = rd_data;
		case (state_q)
			S_ADD_RD: begin
				if (k_q != '0) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_idx = k_q - 1'b1;
				end
			end
			S_ADD_CMP: begin
				if (rd_data.arr_time > time_q) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_idx = k_q;
				end
			end
			S_INS: begin
				cmd.wr_en        = 1'b1;
				cmd.wr_idx       = k_q;
				wr_data.value    = val_q;
				wr_data.seq      = seq_q;
				wr_data.arr_time = time_q;
			end
			S_RD_RD: begin
				if (k_q != fill_q) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_idx = k_q;
				end
			end
			S_RD_FIN: begin
				cmd.adv_en  = 1'b1;
				cmd.adv_cnt = k_q;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			held_value_q <= '0;
			held_seq_q   <= '0;
			done_q       <= 1'b0;
			k_q          <= '0;
			fresh_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q  <= $unsigned(sample_value);
						seq_q  <= sample_seq;
						if (req_type == REQ_ADD) begin
							time_q <= arrival_time;
							if (fill_q == CNT_W'(DEPTH)) begin
								done_q      <= 1'b1;
								status_q    <= ST_ADD_DROP;
								out_value_q <= held_value_q;
							end else begin
								k_q     <= fill_q;
								state_q <= S_ADD_RD;
							end
						end else begin
							time_q     <= now_time;
							k_q        <= '0;
							best_seq_q <= held_seq_q;
							best_val_q <= held_value_q;
							fresh_q    <= 1'b0;
							state_q    <= S_RD_RD;
						end
					end
				end
				S_ADD_RD: begin
					state_q <= (k_q == '0) ? S_INS : S_ADD_CMP;
				end
				S_ADD_CMP: begin
					if (rd_data.arr_time > time_q) begin
						k_q     <= k_q - 1'b1;
						state_q <= S_ADD_RD;
					end else begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					fill_q      <= fill_q + 1'b1;
					done_q      <= 1'b1;
					status_q    <= ST_ADD_OK;
					out_value_q <= held_value_q;
					state_q     <= S_IDLE;
				end
				S_RD_RD: begin
					state_q <= (k_q == fill_q) ? S_RD_FIN : S_RD_CMP;
				end
				S_RD_CMP: begin
					if (rd_data.arr_time <= time_q) begin
						if (rd_data.seq > best_seq_q) begin
							best_seq_q <= rd_data.seq;
							best_val_q <= rd_data.value;
							fresh_q    <= 1'b1;
						end
						k_q     <= k_q + 1'b1;
						state_q <= S_RD_RD;
					end else begin
						state_q <= S_RD_FIN;
					end
				end
				S_RD_FIN: begin
					fill_q <= fill_q - k_q;
					done_q <= 1'b1;
					if (fresh_q) begin
						held_value_q <= best_val_q;
						held_seq_q   <= best_seq_q;
						out_value_q  <= best_val_q;
						status_q     <= ST_RD_FRESH;
					end else begin
						out_value_q <= held_value_q;
						status_q    <= ST_RD_HELD;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_ADD_DROP) |-> (fill_q == CNT_W'(DEPTH)))
		else $error("add dropped while buffer not full");

	a_fresh_newer: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_RD_FRESH) |-> (held_seq_q > $past(held_seq_q)))
		else $error("fresh read did not raise held sequence");

	a_request_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done_q))
		else $error("request neither in progress nor answered");

endmodule
